// ----- rtl/halftime_dual_head_pitch_shifter_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef HALFTIME_DUAL_HEAD_PITCH_SHIFTER_DEFINES_SVH
`define HALFTIME_DUAL_HEAD_PITCH_SHIFTER_DEFINES_SVH

// Next-cycle implication, off while reset is asserted.
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hts check failed");

// Next-cycle implication that also holds through reset.
`define HTS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hts reset check failed");

`endif

// ----- rtl/hts_pkg.sv -----
`default_nettype none

package hts_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int GAIN_BITS     = 17;
    localparam int PCT_BITS      = 7;
    localparam int FADE_OFFSET   = 10;
    localparam int FADE_DEN_MAX  = 137;
    localparam int RECIP_BITS    = 32;
    localparam int NUM_BITS      = 42;

    localparam logic [GAIN_BITS-1:0] UNITY     = 17'd65536;
    localparam logic [NUM_BITS-1:0]  RECIP_NUM = 42'(64'd1000 << 32);

    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIX    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE   = 2'd2;

    typedef enum logic [1:0] {
        TAP_A1,
        TAP_B1,
        TAP_A2,
        TAP_B2
    } t_tap;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PASS,
        ST_WRITE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_WAIT,
        ST_HEADS,
        ST_WET_A,
        ST_WET_B,
        ST_ROUND,
        ST_MIX_A,
        ST_MIX_B,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic cap_x;
        logic ring_wr;
        logic rd_en;
        t_tap rd_sel;
        logic gain_lo;
        logic gain_hi;
        logic gain_clamp;
        logic heads;
        logic wet_a;
        logic wet_b;
        logic round;
        logic mix_a;
        logic mix_b;
        logic out_load;
        logic out_pass;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic enable;
        logic clr_last;
        logic div_busy;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/hts_recip.sv -----
`default_nettype none

module hts_recip #(
    parameter int RING_DEPTH = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [hts_pkg::PCT_BITS-1:0]     i_pct,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [hts_pkg::RECIP_BITS-1:0]        o_quo
);
    import hts_pkg::*;

    localparam int DW = $clog2(RING_DEPTH * FADE_DEN_MAX + 1);
    localparam int CW = $clog2(NUM_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [DW-1:0]       r_rem;
    logic [DW-1:0]       r_div;
    logic [NUM_BITS-1:0] r_num;
    logic [NUM_BITS-1:0] r_quo;
    logic [DW:0]         trial;
    logic                take;
    logic [DW-1:0]       n_div;

    assign n_div = DW'(RING_DEPTH) * (DW'(i_pct) + DW'(FADE_OFFSET));
    assign trial = {r_rem, r_num[NUM_BITS-1]};
    assign take  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= n_div;
            r_num <= RECIP_NUM;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= take ? DW'(trial - {1'b0, r_div}) : DW'(trial);
            r_num <= {r_num[NUM_BITS-2:0], 1'b0};
            r_quo <= {r_quo[NUM_BITS-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo[RECIP_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/hts_dpath.sv -----
`default_nettype none

module hts_dpath #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire hts_pkg::t_cmd                        i_cmd,
    output hts_pkg::t_stat                            o_stat,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hts_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [hts_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_right_sample,
    output logic signed [SAMPLE_BITS-1:0]             o_left_out,
    output logic signed [SAMPLE_BITS-1:0]             o_right_out
);
    import hts_pkg::*;

    localparam int AW        = $clog2(RING_DEPTH);
    localparam int HW        = AW + 1;
    localparam int HALF_SPAN = 2 * RING_DEPTH;
    localparam int HEAD_GAP  = 2 * (RING_DEPTH / 2);
    localparam int SB        = SAMPLE_BITS;
    localparam int VW        = SB + 1;
    localparam int WW        = SB + 2;
    localparam int ACC_W     = SB + 20;
    localparam int MAC_W     = SB + 21;
    localparam int GW        = AW + 32;

    localparam logic [RECIP_BITS-1:0] RECIP_RST =
        32'((64'd1000 << 32) / (64'(RING_DEPTH) * 64'(FADE_OFFSET + FADE_OFFSET)));
    localparam logic signed [ACC_W-1:0] RND_WET = ACC_W'(65536);
    localparam logic signed [MAC_W-1:0] RND_MIX = MAC_W'(32768);
    localparam logic signed [MAC_W-1:0] SMAX    = MAC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [MAC_W-1:0] SMIN    = -SMAX - MAC_W'(1);

    // configuration
    logic                  r_enable;
    logic [GAIN_BITS-1:0]  r_mix;
    logic [RECIP_BITS-1:0] r_recip;
    logic                  fade_wr;
    logic                  div_busy;
    logic                  div_done;
    logic [RECIP_BITS-1:0] div_quo;

    assign fade_wr = i_cfg_we && (i_cfg_index == CFG_FADE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_mix    <= UNITY;
            r_recip  <= RECIP_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_MIX:    r_mix    <= i_cfg_data[GAIN_BITS-1:0];
                    default:    ;
                endcase
            end
            if (div_done) begin
                r_recip <= div_quo;
            end
        end
    end

    hts_recip #(
        .RING_DEPTH (RING_DEPTH)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fade_wr),
        .i_pct   (i_cfg_data[PCT_BITS-1:0]),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // positions
    logic [AW-1:0] r_widx;
    logic [HW-1:0] r_half;
    logic [AW-1:0] r_clr_addr;
    logic [HW:0]   h2_sum;
    logic [HW-1:0] h2;
    logic [AW-1:0] idx1;
    logic [AW-1:0] idx2;
    logic [AW-1:0] nxt1;
    logic [AW-1:0] nxt2;
    logic [AW:0]   lag_w;
    logic [AW-1:0] lag;
    logic [AW-1:0] rd_addr;

    assign h2_sum = {1'b0, r_half} + (HW+1)'(HEAD_GAP);
    assign h2     = (h2_sum >= (HW+1)'(HALF_SPAN)) ? HW'(h2_sum - (HW+1)'(HALF_SPAN))
                                                   : HW'(h2_sum);
    assign idx1   = r_half[HW-1:1];
    assign idx2   = h2[HW-1:1];
    assign nxt1   = (idx1 == AW'(RING_DEPTH - 1)) ? '0 : idx1 + 1'b1;
    assign nxt2   = (idx2 == AW'(RING_DEPTH - 1)) ? '0 : idx2 + 1'b1;
    assign lag_w  = {1'b0, r_widx} - {1'b0, idx1}
                  + ((r_widx < idx1) ? (AW+1)'(RING_DEPTH) : '0);
    assign lag    = lag_w[AW-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            TAP_A1:  rd_addr = idx1;
            TAP_B1:  rd_addr = nxt1;
            TAP_A2:  rd_addr = idx2;
            TAP_B2:  rd_addr = nxt2;
            default: rd_addr = idx1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx     <= '0;
            r_half     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.adv) begin
                r_widx <= (r_widx == AW'(RING_DEPTH - 1)) ? '0 : r_widx + 1'b1;
                r_half <= (r_half == HW'(HALF_SPAN - 1)) ? '0 : r_half + 1'b1;
            end
        end
    end

    // head one gain, reciprocal split in two 16-bit halves
    logic [AW+15:0]       r_plo;
    logic [GW-1:0]        r_gacc;
    logic [GAIN_BITS-1:0] r_g1;
    logic [AW+15:0]       plo;
    logic [AW+15:0]       phi;
    logic [GW-1:0]        gsum;
    logic [AW+15:0]       gsh;
    logic [GAIN_BITS-1:0] g2;
    logic [GAIN_BITS-1:0] mixc;
    logic [GAIN_BITS-1:0] dry_g;

    assign plo   = lag * r_recip[15:0];
    assign phi   = lag * r_recip[31:16];
    assign gsum  = GW'(r_plo) + (GW'(phi) << 16);
    assign gsh   = r_gacc[GW-1:16];
    assign g2    = UNITY - r_g1;
    assign mixc  = (r_mix > UNITY) ? UNITY : r_mix;
    assign dry_g = UNITY - mixc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_lo) begin
            r_plo <= plo;
        end
        if (i_cmd.gain_hi) begin
            r_gacc <= gsum;
        end
        if (i_cmd.gain_clamp) begin
            r_g1 <= (gsh > (AW+16)'(UNITY)) ? UNITY : gsh[GAIN_BITS-1:0];
        end
    end

    logic       r_cap_en;
    t_tap       r_cap_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_sel <= i_cmd.rd_sel;
    end

    logic signed [SB-1:0] x_in [2];
    logic signed [SB-1:0] r_y  [2];

    assign x_in[0]     = i_left_sample;
    assign x_in[1]     = i_right_sample;
    assign o_left_out  = r_y[0];
    assign o_right_out = r_y[1];

    for (genvar c = 0; c < 2; c++) begin : g_ch
        logic signed [SB-1:0]    mem [RING_DEPTH];
        logic signed [SB-1:0]    r_q;
        logic signed [SB-1:0]    r_x;
        logic signed [SB-1:0]    r_tap [4];
        logic signed [VW-1:0]    r_v1;
        logic signed [VW-1:0]    r_v2;
        logic signed [ACC_W-1:0] r_acc;
        logic signed [WW-1:0]    r_wet;
        logic signed [MAC_W-1:0] r_mac;
        logic                    mem_we;
        logic [AW-1:0]           mem_waddr;
        logic signed [SB-1:0]    mem_wdata;
        logic signed [VW-1:0]    v1;
        logic signed [VW-1:0]    v2;
        logic signed [ACC_W-1:0] prod_a;
        logic signed [ACC_W-1:0] prod_b;
        logic signed [ACC_W-1:0] wet_sh;
        logic signed [MAC_W-1:0] prod_c;
        logic signed [MAC_W-1:0] prod_d;
        logic signed [MAC_W-1:0] y_sh;
        logic signed [SB-1:0]    y_sat;

        assign mem_we    = i_cmd.clr || i_cmd.ring_wr;
        assign mem_waddr = i_cmd.clr ? r_clr_addr : r_widx;
        assign mem_wdata = i_cmd.clr ? '0 : r_x;

        always_ff @(posedge i_clk) begin
            if (mem_we) begin
                mem[mem_waddr] <= mem_wdata;
            end
            if (i_cmd.rd_en) begin
                r_q <= mem[rd_addr];
            end
        end

        assign v1 = r_half[0] ? VW'(r_tap[TAP_A1]) + VW'(r_tap[TAP_B1])
                              : VW'(r_tap[TAP_A1]) <<< 1;
        assign v2 = h2[0] ? VW'(r_tap[TAP_A2]) + VW'(r_tap[TAP_B2])
                          : VW'(r_tap[TAP_A2]) <<< 1;

        assign prod_a = r_v1 * $signed({1'b0, r_g1});
        assign prod_b = r_v2 * $signed({1'b0, g2});
        assign wet_sh = (r_acc + RND_WET) >>> 17;
        assign prod_c = r_wet * $signed({1'b0, mixc});
        assign prod_d = r_x * $signed({1'b0, dry_g});
        assign y_sh   = (r_mac + RND_MIX) >>> 16;

        always_comb begin
            if (y_sh > SMAX) begin
                y_sat = SMAX[SB-1:0];
            end else if (y_sh < SMIN) begin
                y_sat = SMIN[SB-1:0];
            end else begin
                y_sat = y_sh[SB-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.cap_x) begin
                r_x <= x_in[c];
            end
            if (r_cap_en) begin
                r_tap[r_cap_sel] <= r_q;
            end
            if (i_cmd.heads) begin
                r_v1 <= v1;
                r_v2 <= v2;
            end
            if (i_cmd.wet_a) begin
                r_acc <= prod_a;
            end else if (i_cmd.wet_b) begin
                r_acc <= r_acc + prod_b;
            end
            if (i_cmd.round) begin
                r_wet <= wet_sh[WW-1:0];
            end
            if (i_cmd.mix_a) begin
                r_mac <= prod_c;
            end else if (i_cmd.mix_b) begin
                r_mac <= r_mac + prod_d;
            end
            if (i_cmd.out_load) begin
                r_y[c] <= i_cmd.out_pass ? r_x : y_sat;
            end
        end
    end

    assign o_stat.enable   = r_enable;
    assign o_stat.clr_last = (r_clr_addr == AW'(RING_DEPTH - 1));
    assign o_stat.div_busy = div_busy || div_done;

endmodule

`default_nettype wire

// ----- rtl/hts_ctrl.sv -----
`default_nettype none

module hts_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire hts_pkg::t_stat  i_stat,
    output hts_pkg::t_cmd        o_cmd
);
    import hts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   open;
    logic   accept;
    logic   slot_free;

    assign open      = (r_state == ST_IDLE) && !i_stat.div_busy;
    assign accept    = open && i_in_valid;
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_stat.enable ? ST_WRITE : ST_PASS;
                end
            end
            ST_PASS:  if (slot_free) n_state = ST_IDLE;
            ST_WRITE: n_state = ST_RD0;
            ST_RD0:   n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_RD3;
            ST_RD3:   n_state = ST_WAIT;
            ST_WAIT:  n_state = ST_HEADS;
            ST_HEADS: n_state = ST_WET_A;
            ST_WET_A: n_state = ST_WET_B;
            ST_WET_B: n_state = ST_ROUND;
            ST_ROUND: n_state = ST_MIX_A;
            ST_MIX_A: n_state = ST_MIX_B;
            ST_MIX_B: n_state = ST_DONE;
            ST_DONE:  if (slot_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr = 1'b1;
            ST_IDLE:  o_cmd.cap_x = accept;
            ST_PASS: begin
                o_cmd.out_load = slot_free;
                o_cmd.out_pass = 1'b1;
            end
            ST_WRITE: o_cmd.ring_wr = 1'b1;
            ST_RD0: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_A1;
                o_cmd.gain_lo = 1'b1;
            end
            ST_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_B1;
                o_cmd.gain_hi = 1'b1;
            end
            ST_RD2: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = TAP_A2;
                o_cmd.gain_clamp = 1'b1;
            end
            ST_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = TAP_B2;
            end
            ST_WAIT:  ;
            ST_HEADS: o_cmd.heads = 1'b1;
            ST_WET_A: o_cmd.wet_a = 1'b1;
            ST_WET_B: o_cmd.wet_b = 1'b1;
            ST_ROUND: o_cmd.round = 1'b1;
            ST_MIX_A: o_cmd.mix_a = 1'b1;
            ST_MIX_B: o_cmd.mix_b = 1'b1;
            ST_DONE: begin
                o_cmd.out_load = slot_free;
                o_cmd.adv      = slot_free;
            end
            default:  ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !open;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/halftime_dual_head_pitch_shifter.sv -----
// Enabled, a frame is written to the ring, read at four taps per channel, then
// goes through the two multiply-accumulate passes before its result is registered;
// disabled, the input is registered straight out. One frame at a time is in flight.
// Reset: synchronous, active low; clears control, then zeroes both rings with
// input stalled. A fade write stalls input while the reciprocal divider runs.
// Configuration is taken at any time.
`default_nettype none

module halftime_dual_head_pitch_shifter #(
    parameter int RING_DEPTH  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]        i_right_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]             o_left_out,
    output logic signed [SAMPLE_BITS-1:0]             o_right_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hts_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [hts_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import hts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hts_dpath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out)
    );

endmodule

`default_nettype wire

// ----- rtl/hts_chk.sv -----
`default_nettype none

`include "halftime_dual_head_pitch_shifter_defines.svh"

module hts_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_stall,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic [SAMPLE_BITS-1:0]               i_left_out,
    input  wire logic [SAMPLE_BITS-1:0]               i_right_out,
    input  wire logic                                 i_cfg_we,
    input  wire logic [hts_pkg::CFG_IDX_BITS-1:0]     i_cfg_index
);
    import hts_pkg::*;

    // one frame in flight: a taken input beat closes the input side
    `HTS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)
    // fade write starts the divider, which holds off input
    `HTS_ASSERT_NEXT(a_fade_stalls, i_clk, i_rst_n, i_cfg_we && (i_cfg_index == CFG_FADE), i_in_stall)
    // reset leaves no result pending and the ring clear pass running
    `HTS_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid && i_in_stall)
    `HTS_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    `HTS_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_left_out) && $stable(i_right_out))

endmodule

bind halftime_dual_head_pitch_shifter hts_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_hts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_left_out  (o_left_out),
    .i_right_out (o_right_out),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;

    localparam int SW            = 24;
    localparam int CFG_W         = hts_pkg::CFG_DATA_BITS;
    localparam int DEPTH         = 65536;
    localparam int HALF_SPAN     = 2 * DEPTH;
    localparam longint SMAX      = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SMIN      = -SMAX - 1;
    localparam int IDLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_FRAMES = 450;
    localparam int DRAIN_CYCLES  = 40;
    localparam int N_ROWS        = 34;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } t_frame;

    typedef enum logic {
        ROW_CFG,
        ROW_FRAME
    } t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [hts_pkg::CFG_IDX_BITS-1:0]   idx;
        logic [hts_pkg::CFG_DATA_BITS-1:0]  val;
        logic [SW-1:0]                      l;
        logic [SW-1:0]                      r;
        logic                               typed;
        logic [SW-1:0]                      el;
        logic [SW-1:0]                      er;
    } t_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic signed [SW-1:0]               i_left_sample;
    logic signed [SW-1:0]               i_right_sample;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic signed [SW-1:0]               o_left_out;
    logic signed [SW-1:0]               o_right_out;
    logic                               i_cfg_we;
    logic [hts_pkg::CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [hts_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    halftime_dual_head_pitch_shifter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shifter state as the block should hold it
    logic signed [SW-1:0]               ring_l [DEPTH];
    logic signed [SW-1:0]               ring_r [DEPTH];
    int unsigned                        wr_pos;
    int unsigned                        head_half;
    bit                                 en_q;
    logic [hts_pkg::CFG_DATA_BITS-1:0]  mix_q;
    logic [hts_pkg::PCT_BITS-1:0]       fade_q;
    longint unsigned                    recip_q;

    t_frame due_frames [$];
    int     mismatch_count = 0;
    bit     calm;
    bit     hold_go;

    const t_row directed_rows [N_ROWS] = '{
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h7FFFFF, 1'b1, 24'h800000, 24'h7FFFFF},
        '{ROW_FRAME, '0, '0, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000, 24'hFFFFFF},
        '{ROW_FRAME, '0, '0, 24'h555555, 24'hAAAAAA, 1'b1, 24'h555555, 24'hAAAAAA},
        '{ROW_CFG, hts_pkg::CFG_ENABLE, 17'd1, '0, '0, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_MIX, 17'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h7FFFFF, 1'b1, 24'h800000, 24'h7FFFFF},
        '{ROW_FRAME, '0, '0, 24'h123456, 24'hFEDCBA, 1'b1, 24'h123456, 24'hFEDCBA},
        '{ROW_CFG, hts_pkg::CFG_MIX, 17'd65536, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h800000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h000001, 24'hFFFFFF, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_MIX, 17'd131071, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h000000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h400000, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_FADE, 17'd127, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h3FFFFF, 24'hC00000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_FADE, 17'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h000000, 24'h7FFFFF, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h000000, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_FADE, 17'd100, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h2AAAAA, 24'hD55555, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_MIX, 17'd32768, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h800000, 24'h7FFFFF, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_ENABLE, 17'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h7FFFFF, 24'h800000, 1'b1, 24'h7FFFFF, 24'h800000},
        '{ROW_CFG, hts_pkg::CFG_ENABLE, 17'd1, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 24'h654321, 24'h9ABCDE, 1'b0, '0, '0},
        '{ROW_CFG, hts_pkg::CFG_FADE, 17'd10, '0, '0, 1'b0, '0, '0}
    };

    function automatic longint unsigned fade_recip(input logic [hts_pkg::PCT_BITS-1:0] pct);
        return (64'd1000 << 32) / (64'(DEPTH) * (64'(pct) + 64'd10));
    endfunction

    // head value in half-LSB units
    function automatic longint head_sum(input bit ch, input int unsigned half);
        int unsigned idx;
        int unsigned nxt;
        longint      a;
        longint      b;
        idx = half >> 1;
        nxt = (idx + 1) % DEPTH;
        a = ch ? longint'(ring_r[idx]) : longint'(ring_l[idx]);
        b = ch ? longint'(ring_r[nxt]) : longint'(ring_l[nxt]);
        return ((half & 1) != 0) ? a + b : 2 * a;
    endfunction

    function automatic logic signed [SW-1:0] blend(input bit ch, input longint x,
                                                   input int unsigned h1, h2,
                                                   input longint g1, mix);
        longint wet;
        longint acc;
        wet = (head_sum(ch, h1) * g1 + head_sum(ch, h2) * (65536 - g1) + 65536) >>> 17;
        acc = (wet * mix + x * (65536 - mix) + 32768) >>> 16;
        if (acc > SMAX) acc = SMAX;
        if (acc < SMIN) acc = SMIN;
        return acc[SW-1:0];
    endfunction

    task automatic predict_frame(input logic signed [SW-1:0] xl, xr, output t_frame y);
        int unsigned     h1;
        int unsigned     h2;
        int unsigned     lag;
        longint unsigned g;
        longint          g1;
        longint          mix;
        if (!en_q) begin
            y.left  = xl;
            y.right = xr;
        end else begin
            h1   = head_half % HALF_SPAN;
            h2   = (h1 + DEPTH) % HALF_SPAN;
            lag  = (wr_pos + DEPTH - (h1 >> 1)) % DEPTH;
            g    = (64'(lag) * recip_q) >> 16;
            g1   = (g > 65536) ? 65536 : longint'(g);
            mix  = (mix_q > 17'd65536) ? 65536 : longint'(mix_q);
            // new sample lands before the heads read
            ring_l[wr_pos] = xl;
            ring_r[wr_pos] = xr;
            y.left    = blend(1'b0, xl, h1, h2, g1, mix);
            y.right   = blend(1'b1, xr, h1, h2, g1, mix);
            wr_pos    = (wr_pos + 1) % DEPTH;
            head_half = (h1 + 1) % HALF_SPAN;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [hts_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [hts_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hts_pkg::CFG_ENABLE: en_q = val[0];
            hts_pkg::CFG_MIX:    mix_q = val;
            hts_pkg::CFG_FADE: begin
                fade_q  = val[hts_pkg::PCT_BITS-1:0];
                recip_q = fade_recip(fade_q);
            end
            default: ;
        endcase
    endtask

    task automatic drive_frame(input logic signed [SW-1:0] l, r, input bit typed,
                               input logic signed [SW-1:0] el, er);
        t_frame want;
        if (!calm && $urandom_range(99) < 6) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_frame(l, r, want);
        if (typed) begin
            want.left  = el;
            want.right = er;
        end
        due_frames.push_back(want);
    endtask

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(15))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return '0;
            3:       return '1;
            default: return SW'($urandom());
        endcase
    endfunction

    always @(posedge i_clk) begin : check_beat
        t_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_frames.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing due: %0d %0d",
                                          o_left_out, o_right_out));
            end else begin
                want = due_frames.pop_front();
                if (o_left_out !== want.left)
                    report_mismatch($sformatf("left_out got %0d want %0d",
                                              o_left_out, want.left));
                if (o_right_out !== want.right)
                    report_mismatch($sformatf("right_out got %0d want %0d",
                                              o_right_out, want.right));
            end
        end
    end

    initial begin : receiver
        bit held;
        held        = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !held) begin
                // long hold-off so the block backs up into its input
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 6);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_row                               row;
        int                                 sent;
        int                                 phase;
        int                                 len;
        logic [hts_pkg::CFG_DATA_BITS-1:0]  cfg_val;
        logic signed [SW-1:0]               l;
        logic signed [SW-1:0]               r;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = hts_pkg::CFG_ENABLE;
        i_cfg_data     = '0;
        calm           = 1'b0;
        hold_go        = 1'b0;
        foreach (ring_l[k]) begin
            ring_l[k] = '0;
            ring_r[k] = '0;
        end
        wr_pos    = 0;
        head_half = 0;
        en_q      = 1'b0;
        mix_q     = hts_pkg::UNITY;
        fade_q    = 7'd10;
        recip_q   = fade_recip(fade_q);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.val);
            end else begin
                drive_frame(row.l, row.r, row.typed, row.el, row.er);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_FRAMES) begin
            settle();
            cfg_val    = '0;
            cfg_val[0] = (phase == 2) || ($urandom_range(99) < 85);
            write_reg(hts_pkg::CFG_ENABLE, cfg_val);
            if ($urandom_range(1) == 1) begin
                case ($urandom_range(4))
                    0:       cfg_val = '0;
                    1:       cfg_val = hts_pkg::UNITY;
                    2:       cfg_val = '1;
                    3:       cfg_val = CFG_W'($urandom_range(65536));
                    default: cfg_val = CFG_W'($urandom_range(131071, 65537));
                endcase
                write_reg(hts_pkg::CFG_MIX, cfg_val);
            end
            if ($urandom_range(2) == 0) begin
                case ($urandom_range(3))
                    0:       cfg_val = '0;
                    1:       cfg_val = 17'd100;
                    2:       cfg_val = 17'd127;
                    default: cfg_val = CFG_W'($urandom_range(127));
                endcase
                write_reg(hts_pkg::CFG_FADE, cfg_val);
            end
            calm = (phase == 4);
            if (phase == 2) hold_go = 1'b1;
            len = $urandom_range(60, 20);
            repeat (len) begin
                l = rand_sample();
                r = rand_sample();
                drive_frame(l, r, 1'b0, '0, '0);
            end
            sent += len;
            phase++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_frames.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", due_frames.size()));
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
